[hw/rtl/bfa_pkg.sv]
// shared types and codes of the best-fit block allocator
package bfa_pkg;

	localparam int KEY_W  = 32;
	localparam int SZ_W   = 30;
	localparam int STAT_W = 4;
	localparam int CNT_W  = 6;

	localparam logic [SZ_W-1:0] TOTAL_RST = 30'd65536;

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_QUERY   = 2'd2;
	localparam logic [1:0] CMD_COMPACT = 2'd3;

	localparam logic [STAT_W-1:0] ST_ALLOC     = 4'd0;
	localparam logic [STAT_W-1:0] ST_DUP       = 4'd1;
	localparam logic [STAT_W-1:0] ST_NOSPACE   = 4'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 4'd3;
	localparam logic [STAT_W-1:0] ST_FREED     = 4'd4;
	localparam logic [STAT_W-1:0] ST_FREE_NF   = 4'd5;
	localparam logic [STAT_W-1:0] ST_FOUND     = 4'd6;
	localparam logic [STAT_W-1:0] ST_QUERY_NF  = 4'd7;
	localparam logic [STAT_W-1:0] ST_COMPACTED = 4'd8;
	localparam logic [STAT_W-1:0] ST_MOVED     = 4'd9;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [SZ_W-1:0]  start;
		logic [SZ_W-1:0]  len;
	} blk_ent_t;

	typedef struct packed {
		logic [SZ_W-1:0] start;
		logic [SZ_W-1:0] len;
	} hole_ent_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [KEY_W-1:0]  key;
		logic [SZ_W-1:0]   start;
		logic [SZ_W-1:0]   size;
		logic [SZ_W-1:0]   old;
		logic [CNT_W-1:0]  cnt;
		logic              last;
	} res_t;

endpackage

[hw/rtl/bfa_bmem.sv]
// block table memory, one write and one registered read port
module bfa_bmem import bfa_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  blk_ent_t      wdata,
	input  logic [AW-1:0] raddr,
	output blk_ent_t      rdata
);

	blk_ent_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/bfa_hmem.sv]
// hole table memory with entry zero covering the whole space after init
module bfa_hmem import bfa_pkg::*; #(
	parameter int DEPTH = 33,
	parameter int AW    = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            init,
	input  logic [SZ_W-1:0] total,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  hole_ent_t       wdata,
	input  logic [AW-1:0]   raddr,
	output hole_ent_t       rdata
);

	hole_ent_t mem [DEPTH];
	hole_ent_t rd_s1;
	logic      fresh_q;
	logic      fresh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
		end else if (init) begin
			fresh_q <= 1'b1;
		end else if (we && waddr == '0) begin
			fresh_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1    <= mem[raddr];
		fresh_s1 <= fresh_q && raddr == '0;
	end

	always_comb begin
		rdata = rd_s1;
		if (fresh_s1) begin
			rdata.start = '0;
			rdata.len   = total;
		end
	end

endmodule

[hw/rtl/best_fit_named_block_allocator.sv]
// best-fit named block allocator top level: sequencer over block and hole tables
//
//   channel | signals                                  | direction
//   cfg     | cfg_we, cfg_wdata                        | in
//   in      | in_valid, in_stall, cmd, block_key, ...  | in (stall out)
//   out     | out_valid, out_stall, status, ... last   | out (stall in)
//
// one request at a time; alloc, free and query first scan the block table for the key.
// alloc then scans the hole table for the best fit, free scans it for the place of the
// freed space, and both shift the hole table tail when a hole goes away or comes in.
// compact walks the block table once per block: a first pass counts the moves, and a
// second pass, run only when some block moves, writes and reports each move.
// reset or a cfg write clears all blocks and leaves one hole of total_size (none if it is zero).
// an output register holds each result; a stalled output pauses the sequencer where it must emit.
module best_fit_named_block_allocator import bfa_pkg::*; #(
	parameter int MAX_BLOCKS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SZ_W-1:0]   cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [KEY_W-1:0]  block_key,
	input  logic [SZ_W-1:0]   req_size,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic [KEY_W-1:0]  block_key_res,
	output logic [SZ_W-1:0]   start_addr,
	output logic [SZ_W-1:0]   block_size,
	output logic [SZ_W-1:0]   prev_start,
	output logic [CNT_W-1:0]  move_total,
	output logic              last
);

	localparam int HDEPTH = MAX_BLOCKS + 1;
	localparam int BAW    = $clog2(MAX_BLOCKS);
	localparam int HAW    = $clog2(HDEPTH);
	localparam int SW     = $clog2(MAX_BLOCKS + 2);
	localparam int BCW    = $clog2(MAX_BLOCKS + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_BSCAN = 4'd1;
	localparam logic [3:0] S_BDEC  = 4'd2;
	localparam logic [3:0] S_HBEST = 4'd3;
	localparam logic [3:0] S_HDEC  = 4'd4;
	localparam logic [3:0] S_HPOS  = 4'd5;
	localparam logic [3:0] S_HADD  = 4'd6;
	localparam logic [3:0] S_SHDN  = 4'd7;
	localparam logic [3:0] S_SHUP  = 4'd8;
	localparam logic [3:0] S_CSCAN = 4'd9;
	localparam logic [3:0] S_CPICK = 4'd10;
	localparam logic [3:0] S_CSUM  = 4'd11;
	localparam logic [3:0] S_CFIN  = 4'd12;

	logic [3:0]            state_q, state_d;
	logic [1:0]            cmd_q, cmd_d;
	logic [KEY_W-1:0]      key_q, key_d;
	logic [SZ_W-1:0]       size_q, size_d;
	logic [SZ_W-1:0]       total_q;
	logic [MAX_BLOCKS-1:0] valid_q, valid_d;
	logic [MAX_BLOCKS-1:0] placed_q, placed_d;
	logic [SW-1:0]         hcnt_q, hcnt_d;
	logic [SW-1:0]         sc_q, sc_d;
	logic [SW-1:0]         lim_q, lim_d;
	logic                  dir_q, dir_d;
	logic                  vld_s1, vld_d;
	logic [SW-1:0]         idx_s1, idx_d;
	logic                  hit_q, hit_d;
	logic [BAW-1:0]        hidx_q, hidx_d;
	logic [SZ_W-1:0]       hstart_q, hstart_d;
	logic [SZ_W-1:0]       hlen_q, hlen_d;
	logic [BAW-1:0]        slot_q, slot_d;
	logic                  bfound_q, bfound_d;
	logic [SW-1:0]         bidx_q, bidx_d;
	logic [SZ_W-1:0]       bstart_q, bstart_d;
	logic [SZ_W-1:0]       blen_q, blen_d;
	logic                  pf_q, pf_d;
	logic [SW-1:0]         p_q, p_d;
	hole_ent_t             prev_q, prev_d;
	hole_ent_t             cur_q, cur_d;
	logic                  pk_q, pk_d;
	logic [BAW-1:0]        pidx_q, pidx_d;
	logic [KEY_W-1:0]      pkey_q, pkey_d;
	logic [SZ_W-1:0]       pstart_q, pstart_d;
	logic [SZ_W-1:0]       plen_q, plen_d;
	logic                  pass_q, pass_d;
	logic [SZ_W-1:0]       addr_q, addr_d;
	logic [BCW-1:0]        moved_q, moved_d;
	logic [BCW-1:0]        emitted_q, emitted_d;
	logic                  out_valid_q;
	res_t                  res_q, res_d;
	logic                  emit;

	logic                  issue, sdone, scanning, out_free, free_any;
	logic [SW-1:0]         ridx, p_eff, pm1, pp1, wup, wdn;
	logic [BAW-1:0]        free_idx;
	logic [SZ_W:0]         prev_end, new_end;
	logic                  mp, mn;
	logic                  bwe, hwe;
	logic [BAW-1:0]        bwaddr;
	logic [HAW-1:0]        hwaddr;
	blk_ent_t              bwdata, brd;
	hole_ent_t             hwdata, hrd;
	logic [BAW-1:0]        ib;

	bfa_bmem #(.DEPTH(MAX_BLOCKS), .AW(BAW)) u_bmem (
		.clk   (clk),
		.we    (bwe),
		.waddr (bwaddr),
		.wdata (bwdata),
		.raddr (ridx[BAW-1:0]),
		.rdata (brd)
	);

	bfa_hmem #(.DEPTH(HDEPTH), .AW(HAW)) u_hmem (
		.clk    (clk),
		.arst_n (arst_n),
		.init   (cfg_we),
		.total  (total_q),
		.we     (hwe),
		.waddr  (hwaddr),
		.wdata  (hwdata),
		.raddr  (ridx[HAW-1:0]),
		.rdata  (hrd)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign status        = res_q.status;
	assign block_key_res = res_q.key;
	assign start_addr    = res_q.start;
	assign block_size    = res_q.size;
	assign prev_start    = res_q.old;
	assign move_total    = res_q.cnt;
	assign last          = res_q.last;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = BAW'(i);
			end
		end
	end

	assign issue    = dir_q ? (sc_q > lim_q) : (sc_q < lim_q);
	assign ridx     = dir_q ? sc_q - 1'b1 : sc_q;
	assign sdone    = !issue && !vld_s1;
	assign scanning = (state_q == S_BSCAN) || (state_q == S_HBEST) || (state_q == S_HPOS) ||
		(state_q == S_SHDN) || (state_q == S_SHUP) || (state_q == S_CSCAN);
	assign p_eff    = pf_q ? p_q : hcnt_q;
	assign pm1      = p_eff - 1'b1;
	assign pp1      = p_eff + 1'b1;
	assign wup      = idx_s1 + 1'b1;
	assign wdn      = idx_s1 - 1'b1;
	assign ib       = idx_s1[BAW-1:0];
	assign prev_end = {1'b0, prev_q.start} + {1'b0, prev_q.len};
	assign new_end  = {1'b0, hstart_q} + {1'b0, hlen_q};
	assign mp       = (p_eff != '0) && (prev_end == {1'b0, hstart_q});
	assign mn       = pf_q && (new_end == {1'b0, cur_q.start});

	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		key_d     = key_q;
		size_d    = size_q;
		valid_d   = valid_q;
		placed_d  = placed_q;
		hcnt_d    = hcnt_q;
		sc_d      = sc_q;
		lim_d     = lim_q;
		dir_d     = dir_q;
		vld_d     = 1'b0;
		idx_d     = idx_s1;
		hit_d     = hit_q;
		hidx_d    = hidx_q;
		hstart_d  = hstart_q;
		hlen_d    = hlen_q;
		slot_d    = slot_q;
		bfound_d  = bfound_q;
		bidx_d    = bidx_q;
		bstart_d  = bstart_q;
		blen_d    = blen_q;
		pf_d      = pf_q;
		p_d       = p_q;
		prev_d    = prev_q;
		cur_d     = cur_q;
		pk_d      = pk_q;
		pidx_d    = pidx_q;
		pkey_d    = pkey_q;
		pstart_d  = pstart_q;
		plen_d    = plen_q;
		pass_d    = pass_q;
		addr_d    = addr_q;
		moved_d   = moved_q;
		emitted_d = emitted_q;
		emit      = 1'b0;
		res_d     = '0;
		bwe       = 1'b0;
		bwaddr    = slot_q;
		bwdata    = '0;
		hwe       = 1'b0;
		hwaddr    = '0;
		hwdata    = '0;

		if (scanning && issue) begin
			vld_d = 1'b1;
			idx_d = ridx;
			sc_d  = dir_q ? sc_q - 1'b1 : sc_q + 1'b1;
		end

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_d  = cmd;
					key_d  = block_key;
					size_d = req_size;
					sc_d   = '0;
					lim_d  = SW'(MAX_BLOCKS);
					dir_d  = 1'b0;
					if (cmd == CMD_COMPACT) begin
						pass_d   = 1'b0;
						placed_d = '0;
						addr_d   = '0;
						moved_d  = '0;
						pk_d     = 1'b0;
						state_d  = S_CSCAN;
					end else begin
						hit_d   = 1'b0;
						state_d = S_BSCAN;
					end
				end
			end
			S_BSCAN: begin
				if (vld_s1 && valid_q[ib] && brd.key == key_q && !hit_q) begin
					hit_d    = 1'b1;
					hidx_d   = ib;
					hstart_d = brd.start;
					hlen_d   = brd.len;
				end
				if (sdone) begin
					state_d = S_BDEC;
				end
			end
			S_BDEC: begin
				if (out_free) begin
					emit      = 1'b1;
					res_d.key = key_q;
					res_d.last = 1'b1;
					state_d   = S_IDLE;
					sc_d      = '0;
					lim_d     = hcnt_q;
					dir_d     = 1'b0;
					case (cmd_q)
						CMD_ALLOC: begin
							if (hit_q) begin
								res_d.status = ST_DUP;
							end else if (!free_any) begin
								res_d.status = ST_FULL;
							end else begin
								emit     = 1'b0;
								slot_d   = free_idx;
								bfound_d = 1'b0;
								state_d  = S_HBEST;
							end
						end
						CMD_FREE: begin
							if (!hit_q) begin
								res_d.status = ST_FREE_NF;
							end else begin
								res_d.status = ST_FREED;
								res_d.start  = hstart_q;
								res_d.size   = hlen_q;
								valid_d[hidx_q] = 1'b0;
								if (hlen_q != '0) begin
									pf_d    = 1'b0;
									state_d = S_HPOS;
								end
							end
						end
						default: begin
							if (!hit_q) begin
								res_d.status = ST_QUERY_NF;
							end else begin
								res_d.status = ST_FOUND;
								res_d.start  = hstart_q;
								res_d.size   = hlen_q;
							end
						end
					endcase
				end
			end
			S_HBEST: begin
				if (vld_s1 && hrd.len >= size_q && (!bfound_q || hrd.len < blen_q)) begin
					bfound_d = 1'b1;
					bidx_d   = idx_s1;
					bstart_d = hrd.start;
					blen_d   = hrd.len;
				end
				if (sdone) begin
					state_d = S_HDEC;
				end
			end
			S_HDEC: begin
				if (out_free) begin
					emit       = 1'b1;
					res_d.key  = key_q;
					res_d.last = 1'b1;
					state_d    = S_IDLE;
					if (!bfound_q) begin
						res_d.status = ST_NOSPACE;
					end else begin
						res_d.status = ST_ALLOC;
						res_d.start  = bstart_q;
						res_d.size   = size_q;
						bwe          = 1'b1;
						bwaddr       = slot_q;
						bwdata.key   = key_q;
						bwdata.start = bstart_q;
						bwdata.len   = size_q;
						valid_d[slot_q] = 1'b1;
						if (blen_q != size_q) begin
							hwe          = 1'b1;
							hwaddr       = bidx_q[HAW-1:0];
							hwdata.start = bstart_q + size_q;
							hwdata.len   = blen_q - size_q;
						end else begin
							sc_d    = bidx_q + 1'b1;
							lim_d   = hcnt_q;
							dir_d   = 1'b0;
							state_d = S_SHDN;
						end
					end
				end
			end
			S_HPOS: begin
				if (vld_s1 && !pf_q) begin
					if (hrd.start >= hstart_q) begin
						pf_d  = 1'b1;
						p_d   = idx_s1;
						cur_d = hrd;
					end else begin
						prev_d = hrd;
					end
				end
				if (sdone) begin
					state_d = S_HADD;
				end
			end
			S_HADD: begin
				state_d = S_IDLE;
				if (mp && mn) begin
					hwe          = 1'b1;
					hwaddr       = pm1[HAW-1:0];
					hwdata.start = prev_q.start;
					hwdata.len   = prev_q.len + hlen_q + cur_q.len;
					sc_d         = pp1;
					lim_d        = hcnt_q;
					dir_d        = 1'b0;
					state_d      = S_SHDN;
				end else if (mp) begin
					hwe          = 1'b1;
					hwaddr       = pm1[HAW-1:0];
					hwdata.start = prev_q.start;
					hwdata.len   = prev_q.len + hlen_q;
				end else if (mn) begin
					hwe          = 1'b1;
					hwaddr       = p_eff[HAW-1:0];
					hwdata.start = hstart_q;
					hwdata.len   = hlen_q + cur_q.len;
				end else if (hcnt_q < SW'(HDEPTH)) begin
					sc_d    = hcnt_q;
					lim_d   = p_eff;
					dir_d   = 1'b1;
					state_d = S_SHUP;
				end
			end
			S_SHDN: begin
				if (vld_s1) begin
					hwe    = 1'b1;
					hwaddr = wdn[HAW-1:0];
					hwdata = hrd;
				end
				if (sdone) begin
					hcnt_d  = hcnt_q - 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SHUP: begin
				if (vld_s1) begin
					hwe    = 1'b1;
					hwaddr = wup[HAW-1:0];
					hwdata = hrd;
				end
				if (sdone) begin
					hwe          = 1'b1;
					hwaddr       = p_eff[HAW-1:0];
					hwdata.start = hstart_q;
					hwdata.len   = hlen_q;
					hcnt_d       = hcnt_q + 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_CSCAN: begin
				if (vld_s1 && valid_q[ib] && !placed_q[ib] && (!pk_q || brd.start < pstart_q ||
					(brd.start == pstart_q && brd.len < plen_q))) begin
					pk_d     = 1'b1;
					pidx_d   = ib;
					pkey_d   = brd.key;
					pstart_d = brd.start;
					plen_d   = brd.len;
				end
				if (sdone) begin
					state_d = S_CPICK;
				end
			end
			S_CPICK: begin
				if (!pk_q) begin
					state_d = pass_q ? S_CFIN : S_CSUM;
				end else if (!pass_q || out_free) begin
					if (pstart_q != addr_q) begin
						if (!pass_q) begin
							moved_d = moved_q + 1'b1;
						end else begin
							emit         = 1'b1;
							res_d.status = ST_MOVED;
							res_d.key    = pkey_q;
							res_d.start  = addr_q;
							res_d.old    = pstart_q;
							res_d.last   = (emitted_q + 1'b1 == moved_q);
							emitted_d    = emitted_q + 1'b1;
							bwe          = 1'b1;
							bwaddr       = pidx_q;
							bwdata.key   = pkey_q;
							bwdata.start = addr_q;
							bwdata.len   = plen_q;
						end
					end
					placed_d[pidx_q] = 1'b1;
					addr_d  = addr_q + plen_q;
					pk_d    = 1'b0;
					sc_d    = '0;
					lim_d   = SW'(MAX_BLOCKS);
					dir_d   = 1'b0;
					state_d = S_CSCAN;
				end
			end
			S_CSUM: begin
				if (out_free) begin
					emit         = 1'b1;
					res_d.status = ST_COMPACTED;
					res_d.cnt    = CNT_W'(moved_q);
					res_d.last   = (moved_q == '0);
					if (moved_q == '0) begin
						state_d = S_CFIN;
					end else begin
						pass_d    = 1'b1;
						placed_d  = '0;
						addr_d    = '0;
						emitted_d = '0;
						pk_d      = 1'b0;
						sc_d      = '0;
						lim_d     = SW'(MAX_BLOCKS);
						dir_d     = 1'b0;
						state_d   = S_CSCAN;
					end
				end
			end
			S_CFIN: begin
				hwe          = 1'b1;
				hwaddr       = '0;
				hwdata.start = addr_q;
				hwdata.len   = total_q - addr_q;
				hcnt_d       = (addr_q < total_q) ? SW'(1) : '0;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= TOTAL_RST;
			valid_q     <= '0;
			placed_q    <= '0;
			hcnt_q      <= SW'(1);
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			placed_q <= placed_d;
			vld_s1   <= vld_d;
			if (cfg_we) begin
				total_q <= cfg_wdata;
				valid_q <= '0;
				hcnt_q  <= (cfg_wdata != '0) ? SW'(1) : '0;
			end else begin
				valid_q <= valid_d;
				hcnt_q  <= hcnt_d;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q     <= cmd_d;
		key_q     <= key_d;
		size_q    <= size_d;
		sc_q      <= sc_d;
		lim_q     <= lim_d;
		dir_q     <= dir_d;
		idx_s1    <= idx_d;
		hit_q     <= hit_d;
		hidx_q    <= hidx_d;
		hstart_q  <= hstart_d;
		hlen_q    <= hlen_d;
		slot_q    <= slot_d;
		bfound_q  <= bfound_d;
		bidx_q    <= bidx_d;
		bstart_q  <= bstart_d;
		blen_q    <= blen_d;
		pf_q      <= pf_d;
		p_q       <= p_d;
		prev_q    <= prev_d;
		cur_q     <= cur_d;
		pk_q      <= pk_d;
		pidx_q    <= pidx_d;
		pkey_q    <= pkey_d;
		pstart_q  <= pstart_d;
		plen_q    <= plen_d;
		pass_q    <= pass_d;
		addr_q    <= addr_d;
		moved_q   <= moved_d;
		emitted_q <= emitted_d;
		if (emit) begin
			res_q <= res_d;
		end
	end

endmodule

[hw/rtl/bfa_chk.sv]
// port checker for the allocator, bound to the top level
module bfa_chk import bfa_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [STAT_W-1:0] status,
	input logic [KEY_W-1:0]  block_key_res,
	input logic [SZ_W-1:0]   start_addr,
	input logic [SZ_W-1:0]   prev_start,
	input logic [CNT_W-1:0]  move_total,
	input logic              last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(block_key_res))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("transfer not followed by busy");

	a_move_diff: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_MOVED |-> start_addr != prev_start)
		else $error("move record does not change the start");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_COMPACTED && status != ST_MOVED |-> last)
		else $error("single result without last");

	a_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_COMPACTED |-> last == (move_total == '0))
		else $error("summary last flag wrong");

endmodule

bind best_fit_named_block_allocator bfa_chk u_bfa_chk (.*);
